// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/plst_pkg.sv =====
// Package with the constants, codes and control types of the list engine.
`timescale 1ns / 1ps

package plst_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;

  typedef enum logic [2:0] {
    FN_ADDFRONT = 3'd0,
    FN_ADDBACK  = 3'd1,
    FN_POPFRONT = 3'd2,
    FN_POPBACK  = 3'd3,
    FN_CLEAR    = 3'd4,
    FN_INSERT   = 3'd5,
    FN_DELETE   = 3'd6,
    FN_DUMP     = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_PUT,
    DP_TAKE,
    DP_DROP_LAST,
    DP_CLEAR,
    DP_STATUS,
    DP_DUMP_START,
    DP_DUMP_STEP
  } dp_op_t;

  typedef enum logic [1:0] {
    AT_FRONT,
    AT_BACK,
    AT_POS
  } dp_at_t;

  typedef struct packed {
    dp_op_t op;
    dp_at_t at;
    kind_t  kind;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_ok;
    logic dump_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/plst_if.sv =====
// Channel interfaces for commands into and results out of the list engine.
`timescale 1ns / 1ps

interface plst_in_if;
  logic                              valid;
  logic                              ready;
  plst_pkg::func_t                   func;
  logic [plst_pkg::POS_W-1:0]        position;
  logic signed [plst_pkg::DATA_W-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink (input valid, input func, input position, input value, output ready);
endinterface

interface plst_out_if;
  logic                              valid;
  logic                              ready;
  plst_pkg::kind_t                   kind;
  logic signed [plst_pkg::DATA_W-1:0] item;
  logic                              last;

  modport source (output valid, output kind, output item, output last, input ready);
  modport sink (input valid, input kind, input item, input last, output ready);
endinterface

// ===== hw/rtl/plst_ctrl.sv =====
// Controller state machine that decodes commands and sequences dumps.
`timescale 1ns / 1ps

module plst_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  plst_pkg::func_t      in_func,
  output logic                 in_ready,
  input  plst_pkg::dp_status_t status,
  output plst_pkg::dp_cmd_t    cmd
);

  plst_pkg::state_t state_r;
  plst_pkg::state_t state_nxt;
  logic             accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plst_pkg::ST_IDLE: begin
        if (accept && in_func == plst_pkg::FN_DUMP && !status.empty) begin
          state_nxt = plst_pkg::ST_DUMP;
        end
      end
      plst_pkg::ST_DUMP: begin
        if (status.out_free && status.dump_last) begin
          state_nxt = plst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = plst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = plst_pkg::DP_NONE;
    cmd.at   = plst_pkg::AT_FRONT;
    cmd.kind = plst_pkg::KIND_DATA;
    case (state_r)
      plst_pkg::ST_IDLE: begin
        in_ready = status.out_free;
        if (accept) begin
          case (in_func)
            plst_pkg::FN_ADDFRONT, plst_pkg::FN_ADDBACK: begin
              if (status.full) begin
                cmd.op   = plst_pkg::DP_STATUS;
                cmd.kind = plst_pkg::KIND_FULL;
              end else begin
                cmd.op = plst_pkg::DP_PUT;
                cmd.at = (in_func == plst_pkg::FN_ADDFRONT) ? plst_pkg::AT_FRONT
                                                            : plst_pkg::AT_BACK;
              end
            end
            plst_pkg::FN_POPFRONT, plst_pkg::FN_POPBACK, plst_pkg::FN_CLEAR: begin
              if (status.empty) begin
                cmd.op   = plst_pkg::DP_STATUS;
                cmd.kind = plst_pkg::KIND_EMPTY;
              end else if (in_func == plst_pkg::FN_POPFRONT) begin
                cmd.op = plst_pkg::DP_TAKE;
                cmd.at = plst_pkg::AT_FRONT;
              end else if (in_func == plst_pkg::FN_POPBACK) begin
                cmd.op = plst_pkg::DP_DROP_LAST;
              end else begin
                cmd.op = plst_pkg::DP_CLEAR;
              end
            end
            plst_pkg::FN_INSERT: begin
              if (!status.pos_ok) begin
                cmd.op   = plst_pkg::DP_STATUS;
                cmd.kind = plst_pkg::KIND_INVALID;
              end else if (status.full) begin
                cmd.op   = plst_pkg::DP_STATUS;
                cmd.kind = plst_pkg::KIND_FULL;
              end else begin
                cmd.op = plst_pkg::DP_PUT;
                cmd.at = plst_pkg::AT_POS;
              end
            end
            plst_pkg::FN_DELETE: begin
              if (!status.pos_ok) begin
                cmd.op   = plst_pkg::DP_STATUS;
                cmd.kind = plst_pkg::KIND_INVALID;
              end else begin
                cmd.op = plst_pkg::DP_TAKE;
                cmd.at = plst_pkg::AT_POS;
              end
            end
            default: begin
              if (status.empty) begin
                cmd.op   = plst_pkg::DP_STATUS;
                cmd.kind = plst_pkg::KIND_EMPTY;
              end else begin
                cmd.op = plst_pkg::DP_DUMP_START;
              end
            end
          endcase
        end
      end
      plst_pkg::ST_DUMP: begin
        if (status.out_free) begin
          cmd.op = plst_pkg::DP_DUMP_STEP;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/plst_datapath.sv =====
// Datapath with the shifting element cells, element count and result register.
`timescale 1ns / 1ps

module plst_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plst_pkg::dp_cmd_t                   cmd,
  output plst_pkg::dp_status_t                status,
  input  logic [plst_pkg::POS_W-1:0]          in_position,
  input  logic signed [plst_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output plst_pkg::kind_t                     out_kind,
  output logic signed [plst_pkg::DATA_W-1:0]  out_item,
  output logic                                out_last
);

  logic [plst_pkg::DATA_W-1:0] cells_r   [plst_pkg::CAPACITY];
  logic [plst_pkg::DATA_W-1:0] cells_nxt [plst_pkg::CAPACITY];
  logic [plst_pkg::DATA_W-1:0] from_lo   [plst_pkg::CAPACITY];
  logic [plst_pkg::DATA_W-1:0] from_hi   [plst_pkg::CAPACITY];

  logic [plst_pkg::CNT_W-1:0]  count_r;
  logic [plst_pkg::CNT_W-1:0]  count_nxt;
  logic [plst_pkg::IDX_W-1:0]  dump_idx_r;
  logic [plst_pkg::IDX_W-1:0]  dump_idx_nxt;
  logic [plst_pkg::CNT_W-1:0]  edit_idx;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  plst_pkg::kind_t             out_kind_r;
  plst_pkg::kind_t             out_kind_nxt;
  logic [plst_pkg::DATA_W-1:0] out_item_r;
  logic [plst_pkg::DATA_W-1:0] out_item_nxt;
  logic                        out_last_r;
  logic                        out_last_nxt;

  // Each cell sees its two neighbors; an end cell sees itself in place of the missing one.
  for (genvar j = 0; j < plst_pkg::CAPACITY; j++) begin : g_nbr
    if (j == 0) begin : g_first
      assign from_lo[j] = cells_r[j];
    end else begin : g_lo
      assign from_lo[j] = cells_r[j-1];
    end
    if (j == plst_pkg::CAPACITY - 1) begin : g_end
      assign from_hi[j] = cells_r[j];
    end else begin : g_hi
      assign from_hi[j] = cells_r[j+1];
    end
  end

  assign status.empty     = (count_r == '0);
  assign status.full      = (count_r == plst_pkg::CNT_W'(plst_pkg::CAPACITY));
  assign status.pos_ok    = (in_position != '0) &&
                            (in_position <= plst_pkg::POS_W'(count_r));
  assign status.dump_last = ((plst_pkg::CNT_W'(dump_idx_r) + plst_pkg::CNT_W'(1)) == count_r);
  assign status.out_free  = !out_valid_r || out_ready;

  always_comb begin
    case (cmd.at)
      plst_pkg::AT_FRONT: edit_idx = '0;
      plst_pkg::AT_BACK:  edit_idx = count_r;
      plst_pkg::AT_POS: begin
        if (cmd.op == plst_pkg::DP_TAKE) begin
          edit_idx = plst_pkg::CNT_W'(in_position - plst_pkg::POS_W'(1));
        end else begin
          edit_idx = plst_pkg::CNT_W'(in_position);
        end
      end
      default: edit_idx = '0;
    endcase
  end

  always_comb begin
    for (int j = 0; j < plst_pkg::CAPACITY; j++) begin
      cells_nxt[j] = cells_r[j];
      if (cmd.op == plst_pkg::DP_PUT) begin
        if (plst_pkg::CNT_W'(j) == edit_idx) begin
          cells_nxt[j] = in_value;
        end else if (plst_pkg::CNT_W'(j) > edit_idx) begin
          cells_nxt[j] = from_lo[j];
        end
      end else if (cmd.op == plst_pkg::DP_TAKE) begin
        if (plst_pkg::CNT_W'(j) >= edit_idx) begin
          cells_nxt[j] = from_hi[j];
        end
      end
    end
  end

  always_comb begin
    count_nxt     = count_r;
    dump_idx_nxt  = dump_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_item_nxt  = out_item_r;
    out_last_nxt  = out_last_r;
    case (cmd.op)
      plst_pkg::DP_PUT:       count_nxt = count_r + plst_pkg::CNT_W'(1);
      plst_pkg::DP_TAKE,
      plst_pkg::DP_DROP_LAST: count_nxt = count_r - plst_pkg::CNT_W'(1);
      plst_pkg::DP_CLEAR:     count_nxt = '0;
      plst_pkg::DP_STATUS: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = cmd.kind;
        out_item_nxt  = '0;
        out_last_nxt  = 1'b1;
      end
      plst_pkg::DP_DUMP_START: dump_idx_nxt = '0;
      plst_pkg::DP_DUMP_STEP: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = plst_pkg::KIND_DATA;
        out_item_nxt  = cells_r[dump_idx_r];
        out_last_nxt  = status.dump_last;
        dump_idx_nxt  = dump_idx_r + plst_pkg::IDX_W'(1);
      end
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    cells_r    <= cells_nxt;
    dump_idx_r <= dump_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_item_r <= out_item_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_item  = out_item_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// Positional list engine: ordered list of signed words edited by a command stream.
// Timing: a status result is registered and shows in the cycle after its transaction is accepted;
// a dump first moves the controller to its dump state, then loads its first element into the result
// register, and the rest follow one per cycle while the sink takes them. In idle a command is taken
// every cycle while the result register is free; a dump holds the input until its last element is loaded.
// Synchronous active-low reset empties the list and the result register; cell data is not reset.
`timescale 1ns / 1ps

module positional_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  plst_in_if.sink     in_ch,
  plst_out_if.source  out_ch
);

  plst_pkg::dp_cmd_t    cmd;
  plst_pkg::dp_status_t status;

  plst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  plst_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_position (in_ch.position),
    .in_value    (in_ch.value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_item    (out_ch.item),
    .out_last    (out_ch.last)
  );

endmodule

// ===== hw/rtl/plst_checker.sv =====
// Port-level assertion checker for the list engine and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plst_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input plst_pkg::kind_t                    out_kind,
  input logic signed [plst_pkg::DATA_W-1:0] out_item,
  input logic                               out_last
);

  // Status results carry a zero item and close their transaction.
  `ASSERT_CLKD(a_status_single, clk, rst_n, (out_valid && out_kind != plst_pkg::KIND_DATA) |-> (out_item == '0 && out_last))

  // No command is taken while a dump still has elements to stream.
  `ASSERT_CLKD(a_dump_blocks_input, clk, rst_n, (out_valid && out_kind == plst_pkg::KIND_DATA && !out_last) |-> !in_ready)

  // A stalled result holds.
  `ASSERT_CLKD(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))

  // Reset drops any pending result.
  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid)

endmodule

bind positional_list_engine plst_checker u_plst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_item  (out_ch.item),
  .out_last  (out_ch.last)
);

// ===== test/list_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks the results of the positional list engine.
`timescale 1ns / 1ps

package list_scoreboard_pkg;
  import plst_pkg::*;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  item;
    logic                      last;
  } list_result_t;

  class deque_scoreboard;
    logic signed [DATA_W-1:0] cells [CAPACITY];
    int unsigned              count;
    list_result_t             expected_results [$];
    int unsigned              failures;
    int unsigned              n_commands;
    int unsigned              n_results;
    int unsigned              full_reached;
    int unsigned              func_seen [8];
    int unsigned              status_seen [4];

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    function void push_status(kind_t kind);
      list_result_t res;
      res.kind = kind;
      res.item = '0;
      res.last = 1'b1;
      expected_results.push_back(res);
      status_seen[kind]++;
    endfunction

    function void insert_at(int unsigned idx, logic signed [DATA_W-1:0] val);
      int i;
      for (i = count; i > idx; i--) begin
        cells[i] = cells[i-1];
      end
      cells[idx] = val;
      count++;
      if (count == CAPACITY) begin
        full_reached++;
      end
    endfunction

    function void remove_at(int unsigned idx);
      int i;
      for (i = idx; i + 1 < count; i++) begin
        cells[i] = cells[i+1];
      end
      count--;
    endfunction

    function void note_command(func_t func, logic [POS_W-1:0] position,
                               logic signed [DATA_W-1:0] value);
      list_result_t res;
      int i;
      n_commands++;
      func_seen[func]++;
      case (func)
        FN_ADDFRONT: begin
          if (count >= CAPACITY) push_status(KIND_FULL);
          else insert_at(0, value);
        end
        FN_ADDBACK: begin
          if (count >= CAPACITY) push_status(KIND_FULL);
          else insert_at(count, value);
        end
        FN_POPFRONT: begin
          if (count == 0) push_status(KIND_EMPTY);
          else remove_at(0);
        end
        FN_POPBACK: begin
          if (count == 0) push_status(KIND_EMPTY);
          else count--;
        end
        FN_CLEAR: begin
          if (count == 0) push_status(KIND_EMPTY);
          else count = 0;
        end
        FN_INSERT: begin
          if (position == 0 || position > count) push_status(KIND_INVALID);
          else if (count >= CAPACITY) push_status(KIND_FULL);
          else insert_at(int'(position), value);
        end
        FN_DELETE: begin
          if (position == 0 || position > count) push_status(KIND_INVALID);
          else remove_at(int'(position) - 1);
        end
        default: begin
          if (count == 0) begin
            push_status(KIND_EMPTY);
          end else begin
            for (i = 0; i < count; i++) begin
              res.kind = KIND_DATA;
              res.item = cells[i];
              res.last = (i + 1 == count);
              expected_results.push_back(res);
            end
          end
        end
      endcase
    endfunction

    function void check_result(kind_t kind, logic signed [DATA_W-1:0] item, logic last);
      list_result_t want;
      n_results++;
      if (expected_results.size() == 0) begin
        $error("Unexpected result: kind %0d, item %0d, last %0b", kind, item, last);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind) begin
        $error("Mismatch on kind: expected %0d, actual %0d", want.kind, kind);
        failures++;
      end
      if (item !== want.item) begin
        $error("Mismatch on item: expected %0d, actual %0d", want.item, item);
        failures++;
      end
      if (last !== want.last) begin
        $error("Mismatch on last: expected %0b, actual %0b", want.last, last);
        failures++;
      end
    endfunction
  endclass

endpackage

// ===== test/tb_positional_list_engine.sv =====
// Testbench top that drives random and directed command streams into the list engine.
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import plst_pkg::*;
  import list_scoreboard_pkg::*;

  localparam int TOTAL_ITEMS = 240;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 160;
  localparam int TAIL_CYCLES = 20;

  typedef enum logic [1:0] {
    RX_RANDOM,
    RX_STEADY,
    RX_HOLD
  } rx_mode_t;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_ANY,
    MIX_SHRINK
  } mix_t;

  logic clk;
  logic rst_n;

  plst_in_if  in_ch ();
  plst_out_if out_ch ();

  positional_list_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_scoreboard sb;
  rx_mode_t        rx_mode = RX_RANDOM;
  bit              tx_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_mode == RX_HOLD) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_mode = RX_RANDOM;
      end else begin
        out_ch.ready <= (rx_mode == RX_STEADY) || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      sb.check_result(out_ch.kind, out_ch.item, out_ch.last);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [POS_W-1:0] pick_position(int unsigned cnt);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70 && cnt > 0) return POS_W'($urandom_range(cnt, 1));
    if (r < 80) return '0;
    if (r < 90) return POS_W'(cnt + 1);
    return POS_W'($urandom_range(255));
  endfunction

  task automatic send_command(func_t func, logic [POS_W-1:0] position,
                              logic signed [DATA_W-1:0] value);
    if (!tx_steady && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= func;
    in_ch.position <= position;
    in_ch.value    <= value;
    // The transaction is held until the engine takes it.
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_command(func, position, value);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic random_command(mix_t mix);
    int unsigned r;
    func_t       func;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW:
        func = r < 30 ? FN_ADDFRONT : r < 60 ? FN_ADDBACK : r < 85 ? FN_INSERT :
               r < 90 ? FN_DUMP : func_t'($urandom_range(7));
      MIX_SHRINK:
        func = r < 20 ? FN_POPFRONT : r < 35 ? FN_POPBACK : r < 70 ? FN_DELETE :
               r < 73 ? FN_CLEAR : r < 83 ? FN_DUMP : func_t'($urandom_range(7));
      default:
        func = func_t'($urandom_range(7));
    endcase
    send_command(func, pick_position(sb.count), $urandom);
  endtask

  task automatic run_mix(mix_t mix, int n);
    repeat (n) random_command(mix);
  endtask

  task automatic grow_to_full();
    int guard;
    guard = 0;
    while (sb.count < CAPACITY && guard < 80) begin
      random_command(MIX_GROW);
      guard++;
    end
    while (sb.count < CAPACITY) begin
      send_command(FN_ADDBACK, pick_position(sb.count), $urandom);
    end
    send_command(FN_ADDFRONT, pick_position(sb.count), $urandom);
    send_command(FN_ADDBACK, pick_position(sb.count), $urandom);
    send_command(FN_INSERT, POS_W'($urandom_range(CAPACITY, 1)), $urandom);
    send_command(FN_INSERT, pick_position(sb.count), $urandom);
    send_command(FN_DUMP, pick_position(sb.count), $urandom);
  endtask

  task automatic drain_to_empty();
    int guard;
    guard = 0;
    while (sb.count > 0 && guard < 80) begin
      random_command(MIX_SHRINK);
      guard++;
    end
    if (sb.count > 0) begin
      send_command(FN_CLEAR, pick_position(sb.count), $urandom);
    end
    send_command(FN_POPFRONT, pick_position(sb.count), $urandom);
    send_command(FN_POPBACK, pick_position(sb.count), $urandom);
    send_command(FN_DELETE, pick_position(sb.count), $urandom);
    send_command(FN_DUMP, pick_position(sb.count), $urandom);
  endtask

  initial begin
    int episode;
    sb = new();
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FN_DUMP;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(FN_DUMP, 8'd0, 32'sd0);
    send_command(FN_POPFRONT, 8'hff, -32'sd1);
    send_command(FN_POPBACK, 8'd1, 32'sd0);
    send_command(FN_CLEAR, 8'd0, 32'sd0);
    send_command(FN_INSERT, 8'd1, 32'sd5);
    send_command(FN_DELETE, 8'd1, 32'sd0);
    send_command(FN_ADDBACK, 8'd0, 32'sh7fff_ffff);
    send_command(FN_ADDFRONT, 8'd0, 32'sh8000_0000);
    send_command(FN_INSERT, 8'd0, 32'sd1);
    send_command(FN_INSERT, 8'd3, 32'sd1);
    send_command(FN_INSERT, 8'd2, 32'sd0);
    send_command(FN_INSERT, 8'd1, -32'sd1);
    send_command(FN_DUMP, 8'd0, 32'sd0);
    send_command(FN_DELETE, 8'd0, 32'sd0);
    send_command(FN_DELETE, 8'd255, 32'sd0);
    send_command(FN_DELETE, 8'd4, 32'sd0);
    send_command(FN_DELETE, 8'd2, 32'sd0);
    send_command(FN_DUMP, 8'd0, 32'sd0);
    send_command(FN_POPFRONT, 8'd0, 32'sd0);
    send_command(FN_POPBACK, 8'd0, 32'sd0);
    send_command(FN_DUMP, 8'd0, 32'sd0);
    send_command(FN_ADDBACK, 8'haa, 32'sh5555_aaaa);
    send_command(FN_CLEAR, 8'h55, 32'sd0);
    send_command(FN_DUMP, 8'd0, 32'sd0);
    wait_drained();

    episode = 0;
    while (sb.n_commands < TOTAL_ITEMS) begin
      case (episode % 5)
        0: grow_to_full();
        1: begin
          rx_mode = RX_HOLD;
          send_command(FN_DUMP, pick_position(sb.count), $urandom);
          run_mix(MIX_ANY, 25);
        end
        2: begin
          wait_drained();
          while (rx_mode == RX_HOLD) @(posedge clk);
          tx_steady = 1'b1;
          rx_mode   = RX_STEADY;
          run_mix(MIX_ANY, 40);
          tx_steady = 1'b0;
          rx_mode   = RX_RANDOM;
        end
        3: drain_to_empty();
        default: begin
          wait_drained();
          run_mix(MIX_ANY, 30);
        end
      endcase
      episode++;
    end

    wait_drained();
    rx_mode = RX_STEADY;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d commands (%0d inserts, %0d deletes, %0d dumps), %0d results.",
             sb.n_commands, sb.func_seen[FN_INSERT], sb.func_seen[FN_DELETE],
             sb.func_seen[FN_DUMP], sb.n_results);
    $display("Status results: %0d empty, %0d bad position, %0d full; list filled %0d times.",
             sb.status_seen[KIND_EMPTY], sb.status_seen[KIND_INVALID],
             sb.status_seen[KIND_FULL], sb.full_reached);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/plst_pkg.sv
hw/rtl/plst_if.sv
hw/rtl/plst_ctrl.sv
hw/rtl/plst_datapath.sv
hw/rtl/positional_list_engine.sv
hw/rtl/plst_checker.sv
test/list_scoreboard_pkg.sv
test/tb_positional_list_engine.sv
